/* hw/rtl/i2p_pkg.sv */
// Shared types, codes and character tables for the infix to postfix converter.
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  // Input and result words
  typedef struct packed {
    logic [7:0] in_char;
    logic       expr_last;
  } i2p_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       expr_done;
    logic [1:0] error_code;
  } i2p_out_t;

  // Stack entry codes
  typedef enum logic [2:0] {
    C_PAREN = 3'd0,
    C_ADD   = 3'd1,
    C_SUB   = 3'd2,
    C_MUL   = 3'd3,
    C_DIV   = 3'd4,
    C_MOD   = 3'd5,
    C_POW   = 3'd6
  } code_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_OVF   = 2'd1,
    ERR_UNBAL = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    CL_DIGIT,
    CL_OPEN,
    CL_OP,
    CL_CLOSE,
    CL_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DISP,
    S_RD,
    S_EV,
    S_END,
    S_TERM,
    S_FIN
  } st_t;

  typedef enum logic [1:0] {
    MD_OP,
    MD_CLOSE,
    MD_FINAL
  } mode_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic push;
    logic push_op;
    logic emit_char;
    logic pop;
    logic discard;
    logic final_chk;
    logic set_unbal;
    logic emit_term;
    logic flush;
  } i2p_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cls_t cls;
    logic started;
    logic err_any;
    logic last;
    logic cnt_zero;
    logic top_paren;
    logic top_wins;
    logic hold_v;
    logic emit_ok;
    logic out_free;
  } i2p_sts_t;

  function automatic code_t op_code(input logic [7:0] c);
    code_t r;
    r = C_PAREN;
    case (c)
      8'h2B:   r = C_ADD;
      8'h2D:   r = C_SUB;
      8'h2A:   r = C_MUL;
      8'h2F:   r = C_DIV;
      8'h25:   r = C_MOD;
      8'h5E:   r = C_POW;
      default: r = C_PAREN;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input code_t c);
    logic [7:0] r;
    r = 8'h00;
    case (c)
      C_PAREN: r = 8'h28;
      C_ADD:   r = 8'h2B;
      C_SUB:   r = 8'h2D;
      C_MUL:   r = 8'h2A;
      C_DIV:   r = 8'h2F;
      C_MOD:   r = 8'h25;
      C_POW:   r = 8'h5E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] code_prec(input code_t c);
    logic [1:0] r;
    r = 2'd0;
    case (c)
      C_ADD, C_SUB:        r = 2'd1;
      C_MUL, C_DIV, C_MOD: r = 2'd2;
      C_POW:               r = 2'd3;
      default:             r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic cls_t char_class(input logic [7:0] c);
    cls_t r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = CL_DIGIT;
    end else if (c == 8'h28) begin
      r = CL_OPEN;
    end else if (c == 8'h29) begin
      r = CL_CLOSE;
    end else if (op_code(c) != C_PAREN) begin
      r = CL_OP;
    end else begin
      r = CL_OTHER;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/i2p_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/i2p_datapath.sv */
// Datapath: operator stack, stack count, error latch, result hold and output registers.
module i2p_datapath #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  i2p_pkg::i2p_in_t  in_data,
  input  i2p_pkg::i2p_cmd_t cmd,
  output i2p_pkg::i2p_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output i2p_pkg::i2p_out_t out_data
);
  import i2p_pkg::*;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             started_r, started_nxt;
  logic [1:0]       err_r, err_nxt;
  i2p_out_t         hold_r, hold_nxt;
  logic             hold_v_r, hold_v_nxt;
  i2p_out_t         out_r, out_nxt;
  logic             out_v_r, out_v_nxt;

  logic [CNT_W-1:0] cnt_m1;
  logic [2:0]       rd_data;
  code_t            top_code;
  code_t            in_op;
  logic             full;
  logic             emit_any;
  i2p_out_t         new_res;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [2:0]       ram_wdata;

  // Stack storage, read address always tracks the top entry
  i2p_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_m1[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  assign cnt_m1   = count_r - CNT_ONE;
  assign top_code = code_t'(rd_data);
  assign in_op    = op_code(char_r);
  assign full     = (count_r == CNT_FULL);

  assign ram_we    = cmd.start | (cmd.push & ~full);
  assign ram_waddr = cmd.start ? '0 : count_r[ADDR_W-1:0];
  assign ram_wdata = cmd.push_op ? 3'(in_op) : 3'(C_PAREN);

  // Status back to the controller
  always_comb begin
    sts.cls       = char_class(char_r);
    sts.started   = started_r;
    sts.err_any   = (err_r != 2'(ERR_NONE));
    sts.last      = last_r;
    sts.cnt_zero  = (count_r == '0);
    sts.top_paren = (top_code == C_PAREN);
    sts.top_wins  = (top_code != C_PAREN) && (rd_data != 3'd7) &&
                    (code_prec(top_code) >= code_prec(in_op));
    sts.out_free  = ~out_v_r | ~out_stall;
    sts.hold_v    = hold_v_r;
    sts.emit_ok   = ~hold_v_r | ~out_v_r | ~out_stall;
  end

  // Result being produced this cycle
  assign emit_any = cmd.emit_char | cmd.pop | cmd.emit_term;
  always_comb begin
    new_res.out_char   = cmd.emit_char ? char_r :
                         cmd.pop       ? code_char(top_code) : 8'h00;
    new_res.run_last   = 1'b0;
    new_res.expr_done  = cmd.emit_term;
    new_res.error_code = err_r;
  end

  // Next-state logic
  always_comb begin
    char_nxt    = char_r;
    last_nxt    = last_r;
    count_nxt   = count_r;
    started_nxt = started_r;
    err_nxt     = err_r;
    hold_nxt    = hold_r;
    hold_v_nxt  = hold_v_r;
    out_nxt     = out_r;
    out_v_nxt   = out_v_r & out_stall;

    if (cmd.load) begin
      char_nxt = in_data.in_char;
      last_nxt = in_data.expr_last;
    end
    if (cmd.start) begin
      count_nxt   = CNT_ONE;
      err_nxt     = 2'(ERR_NONE);
      started_nxt = 1'b1;
    end
    if (cmd.push) begin
      if (full) begin
        err_nxt = 2'(ERR_OVF);
      end else begin
        count_nxt = count_r + CNT_ONE;
      end
    end
    if (cmd.pop) begin
      count_nxt = cnt_m1;
    end
    if (cmd.discard) begin
      count_nxt = cnt_m1;
      // final close must empty the stack, an inner close must not
      if (cmd.final_chk ? (count_r != CNT_ONE) : (count_r == CNT_ONE)) begin
        err_nxt = 2'(ERR_UNBAL);
      end
    end
    if (cmd.set_unbal) begin
      err_nxt = 2'(ERR_UNBAL);
    end
    if (emit_any) begin
      if (hold_v_r) begin
        out_nxt   = hold_r;
        out_v_nxt = 1'b1;
      end
      hold_nxt   = new_res;
      hold_v_nxt = 1'b1;
    end
    if (cmd.emit_term) begin
      count_nxt   = '0;
      started_nxt = 1'b0;
      err_nxt     = 2'(ERR_NONE);
    end
    if (cmd.flush) begin
      out_nxt          = hold_r;
      out_nxt.run_last = 1'b1;
      out_v_nxt        = 1'b1;
      hold_v_nxt       = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      started_r <= 1'b0;
      err_r     <= 2'(ERR_NONE);
      hold_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      started_r <= started_nxt;
      err_r     <= err_nxt;
      hold_v_r  <= hold_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop || cmd.discard) |-> (count_r != '0))
    else $error("pop from empty stack");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_term |=> (count_r == '0) && !started_r && (err_r == 2'(ERR_NONE)))
    else $error("terminator left expression state behind");

  a_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_any && hold_v_r) || cmd.flush |-> (!out_v_r || !out_stall))
    else $error("output word overwritten while stalled");
`endif

endmodule

/* hw/rtl/i2p_ctrl.sv */
// Controller: sequences character dispatch, stack scans, flush and result release.
module i2p_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2p_pkg::i2p_sts_t sts,
  output i2p_pkg::i2p_cmd_t cmd
);
  import i2p_pkg::*;

  st_t   state_r, state_nxt;
  mode_t mode_r, mode_nxt;

  logic  scan_pop;

  // Stack scan keeps popping while this holds
  always_comb begin
    if (mode_r == MD_OP) begin
      scan_pop = ~sts.cnt_zero & sts.top_wins;
    end else begin
      scan_pop = ~sts.cnt_zero & ~sts.top_paren;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: state_nxt = S_DISP;
      S_DISP: begin
        if (sts.err_any) begin
          state_nxt = S_END;
        end else begin
          unique case (sts.cls)
            CL_DIGIT: if (sts.emit_ok) state_nxt = S_END;
            CL_OP: begin
              mode_nxt  = MD_OP;
              state_nxt = S_RD;
            end
            CL_CLOSE: begin
              mode_nxt  = MD_CLOSE;
              state_nxt = S_RD;
            end
            default: state_nxt = S_END;
          endcase
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        if (scan_pop) begin
          if (sts.emit_ok) state_nxt = S_RD;
        end else if (mode_r == MD_FINAL) begin
          state_nxt = S_TERM;
        end else begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (!sts.last) begin
          state_nxt = S_FIN;
        end else if (sts.err_any) begin
          state_nxt = S_TERM;
        end else begin
          mode_nxt  = MD_FINAL;
          state_nxt = S_RD;
        end
      end
      S_TERM: if (sts.emit_ok) state_nxt = S_FIN;
      S_FIN:  if (!sts.hold_v || sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE:  cmd.load = in_valid;
      S_START: cmd.start = ~sts.started;
      S_DISP: begin
        if (!sts.err_any) begin
          cmd.emit_char = (sts.cls == CL_DIGIT) & sts.emit_ok;
          cmd.push      = (sts.cls == CL_OPEN);
        end
      end
      S_EV: begin
        cmd.final_chk = (mode_r == MD_FINAL);
        if (scan_pop) begin
          cmd.pop = sts.emit_ok;
        end else if (mode_r == MD_OP) begin
          cmd.push    = 1'b1;
          cmd.push_op = 1'b1;
        end else if (sts.cnt_zero) begin
          cmd.set_unbal = 1'b1;
        end else begin
          cmd.discard = 1'b1;
        end
      end
      S_TERM: cmd.emit_term = sts.emit_ok;
      S_FIN:  cmd.flush = sts.hold_v & sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MD_OP;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sts.hold_v)
    else $error("held result left behind at item end");

  a_final_terminates: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV && mode_r == MD_FINAL && !scan_pop) |=> (state_r == S_TERM))
    else $error("final flush did not reach terminator");
`endif

endmodule

/* hw/rtl/infix_to_postfix_converter_top.sv */
// Top level of the infix to postfix converter: controller plus stack datapath.
// A new word is accepted only once the previous word has been fully processed (in_stall while busy).
// An operator or ')' examines stack entries one at a time, each through a registered stack RAM read.
// The last word also runs the closing flush over the stack, then emits the terminator.
// Each result passes through the hold register to the output register; out_stall can stall any of these steps.
// Reset is synchronous, active low: clears counts, flags and valids; stack RAM is not cleared.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2p_pkg::i2p_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output i2p_pkg::i2p_out_t out_data
);
  import i2p_pkg::*;

  i2p_cmd_t cmd;
  i2p_sts_t sts;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2p_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* test/infix_to_postfix_converter_top_test.sv */
// Self-checking testbench for the infix to postfix converter: directed table, then random words.
module infix_to_postfix_converter_top_test;
  import i2p_pkg::*;

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 240;

  // Glyph and precedence per stack code, indexed by code_t
  localparam logic [7:0] GLYPH [7] = '{"(", "+", "-", "*", "/", "%", "^"};
  localparam logic [1:0] RANK [7] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3};

  localparam i2p_out_t NO_WORD = '0;

  // One directed stimulus row; want is used only when typed is set
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    i2p_out_t   want;
  } plan_row_t;

  localparam int PLAN_LEN = 24;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{"7",   1'b0, 1'b1, '{"7", 1'b1, 1'b0, ERR_NONE}},
    '{"+",   1'b0, 1'b0, NO_WORD},
    '{"9",   1'b0, 1'b1, '{"9", 1'b1, 1'b0, ERR_NONE}},
    '{"*",   1'b0, 1'b0, NO_WORD},
    '{"(",   1'b0, 1'b0, NO_WORD},
    '{"0",   1'b0, 1'b1, '{"0", 1'b1, 1'b0, ERR_NONE}},
    '{"-",   1'b0, 1'b0, NO_WORD},
    '{"5",   1'b0, 1'b1, '{"5", 1'b1, 1'b0, ERR_NONE}},
    '{")",   1'b0, 1'b0, NO_WORD},
    '{"^",   1'b0, 1'b0, NO_WORD},
    '{"2",   1'b0, 1'b1, '{"2", 1'b1, 1'b0, ERR_NONE}},
    '{"/",   1'b0, 1'b0, NO_WORD},
    '{"3",   1'b0, 1'b1, '{"3", 1'b1, 1'b0, ERR_NONE}},
    '{"%",   1'b0, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b1, 1'b0, NO_WORD},
    // lone ')' closes the implicit paren: only the terminator, flagged
    '{")",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_UNBAL}},
    // unclosed paren at the end
    '{"(",   1'b0, 1'b0, NO_WORD},
    '{"4",   1'b0, 1'b1, '{"4", 1'b1, 1'b0, ERR_NONE}},
    '{"1",   1'b1, 1'b0, NO_WORD},
    // error then ignored characters
    '{")",   1'b0, 1'b0, NO_WORD},
    '{"8",   1'b0, 1'b0, NO_WORD},
    '{"A",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_UNBAL}},
    // one-character expression
    '{"5",   1'b1, 1'b0, NO_WORD}
  };

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  i2p_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  i2p_out_t out_data;

  infix_to_postfix_converter_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Converter state as the checker sees it
  code_t      ops [64];
  int         depth_n = 0;
  bit         open_seen = 1'b0;
  logic [1:0] err_now = ERR_NONE;
  i2p_out_t   step_out [$];
  i2p_out_t   postfix_q [$];

  int         fail_count = 0;
  bit         row_typed = 1'b0;
  i2p_out_t   row_want = '0;
  bit         in_burst = 1'b0;
  bit         out_burst = 1'b0;
  logic [7:0] expr_chars [$];

  function automatic void add_result(logic [7:0] ch, logic done);
    i2p_out_t r;
    r.out_char = ch;
    r.run_last = 1'b0;
    r.expr_done = done;
    r.error_code = err_now;
    step_out.push_back(r);
  endfunction

  function automatic void push_entry(code_t c);
    if (depth_n >= STACK_DEPTH) begin
      err_now = ERR_OVF;
    end else begin
      ops[depth_n] = c;
      depth_n++;
    end
  endfunction

  function automatic void pop_to_output();
    depth_n--;
    add_result(GLYPH[ops[depth_n]], 1'b0);
  endfunction

  // Pop down to the nearest paren and drop it; at_end applies the final balance rule
  function automatic void unwind(bit at_end);
    while (depth_n > 0 && ops[depth_n - 1] != C_PAREN) begin
      pop_to_output();
    end
    if (depth_n == 0) begin
      err_now = ERR_UNBAL;
    end else begin
      depth_n--;
      if (at_end ? (depth_n != 0) : (depth_n == 0)) err_now = ERR_UNBAL;
    end
  endfunction

  function automatic code_t op_of(logic [7:0] c);
    code_t r;
    case (c)
      "+":     r = C_ADD;
      "-":     r = C_SUB;
      "*":     r = C_MUL;
      "/":     r = C_DIV;
      "%":     r = C_MOD;
      "^":     r = C_POW;
      default: r = C_PAREN;
    endcase
    return r;
  endfunction

  // Postfix words that one input word produces, left in step_out
  function automatic void to_postfix(i2p_in_t w);
    code_t oc;
    step_out = {};
    if (!open_seen) begin
      depth_n = 0;
      err_now = ERR_NONE;
      push_entry(C_PAREN);
      open_seen = 1'b1;
    end
    if (err_now == ERR_NONE) begin
      oc = op_of(w.in_char);
      if (w.in_char >= "0" && w.in_char <= "9") begin
        add_result(w.in_char, 1'b0);
      end else if (w.in_char == "(") begin
        push_entry(C_PAREN);
      end else if (oc != C_PAREN) begin
        while (depth_n > 0 && ops[depth_n - 1] != C_PAREN &&
               RANK[ops[depth_n - 1]] >= RANK[oc]) begin
          pop_to_output();
        end
        push_entry(oc);
      end else if (w.in_char == ")") begin
        unwind(1'b0);
      end
    end
    if (w.expr_last) begin
      if (err_now == ERR_NONE) unwind(1'b1);
      add_result(8'h00, 1'b1);
      depth_n = 0;
      open_seen = 1'b0;
      err_now = ERR_NONE;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
  endfunction

  // Idle length: mostly short, a few long, with runs of no idling at all
  function automatic int idle_len(inout bit quiet_run);
    int r;
    if ($urandom_range(0, 39) == 0) quiet_run = !quiet_run;
    if (quiet_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Present one word at the falling edge and hold it until accepted
  task automatic send_word(logic [7:0] ch, logic last, bit typed, i2p_out_t want);
    int gap;
    @(negedge clk);
    gap = idle_len(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {ch, last};
    row_typed = typed;
    row_want = want;
    do @(posedge clk); while (in_stall);
  endtask

  // Well-formed expression with random operands, operators and nesting
  task automatic build_expr(int operands, int nest_cap);
    int opens;
    opens = 0;
    expr_chars = {};
    for (int k = 0; k < operands; k++) begin
      if (k > 0) expr_chars.push_back(GLYPH[$urandom_range(1, 6)]);
      while (opens < nest_cap && $urandom_range(0, 3) == 0) begin
        expr_chars.push_back("(");
        opens++;
      end
      expr_chars.push_back(8'h30 + 8'($urandom_range(0, 9)));
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        expr_chars.push_back(")");
        opens--;
      end
    end
    repeat (opens) expr_chars.push_back(")");
  endtask

  // Nesting that fills the stack up to and past its depth
  task automatic build_deep();
    bit chain;
    int n;
    chain = $urandom_range(0, 1);
    n = chain ? $urandom_range(13, 18) : $urandom_range(28, 34);
    expr_chars = {};
    repeat (n) begin
      expr_chars.push_back("(");
      if (chain) expr_chars.push_back(GLYPH[$urandom_range(1, 6)]);
    end
    expr_chars.push_back(8'h30 + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 1)) repeat (n) expr_chars.push_back(")");
  endtask

  // Reset, directed table, random expressions, drain
  initial begin : main
    int pick;
    int sent;
    int pos;
    int n;
    sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < PLAN_LEN; k++) begin
      send_word(PLAN[k].ch, PLAN[k].last, PLAN[k].typed, PLAN[k].want);
    end

    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        if (pick < 75) begin
          build_expr($urandom_range(1, 10), $urandom_range(0, 10));
        end else begin
          build_deep();
        end
        // broken sequences: drop a character or add a stray paren
        if (pick >= 62 && pick < 75) begin
          pos = $urandom_range(0, expr_chars.size() - 1);
          case ($urandom_range(0, 2))
            0: if (expr_chars.size() > 1) expr_chars.delete(pos);
            1: expr_chars.insert(pos, "(");
            default: expr_chars.insert(pos, ")");
          endcase
        end
        // characters the converter skips
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            pos = $urandom_range(0, expr_chars.size());
            expr_chars.insert(pos, $urandom_range(0, 1) ? 8'h20 :
                              (8'h80 | 8'($urandom_range(0, 127))));
          end
        end
        foreach (expr_chars[k]) begin
          send_word(expr_chars[k], k == expr_chars.size() - 1, 1'b0, NO_WORD);
        end
        sent += expr_chars.size();
      end else begin
        // raw bytes, any value
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          send_word(8'($urandom_range(0, 255)), k == n - 1, 1'b0, NO_WORD);
        end
        sent += n;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side back-pressure
  initial begin : out_side
    int hold;
    @(posedge rst_n);
    forever begin
      hold = idle_len(out_burst);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Predict on each accepted input word, compare each accepted result word
  always @(posedge clk) begin : scoreboard
    i2p_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        to_postfix(in_data);
        if (row_typed) begin
          postfix_q.push_back(row_want);
        end else begin
          foreach (step_out[k]) postfix_q.push_back(step_out[k]);
        end
      end
      if (out_valid && !out_stall) begin
        if (postfix_q.size() == 0) begin
          $error("result word with none expected: out_char %h", out_data.out_char);
          fail_count++;
        end else begin
          want = postfix_q.pop_front();
          if (out_data.out_char !== want.out_char) begin
            $error("out_char expected %h got %h", want.out_char, out_data.out_char);
            fail_count++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last expected %b got %b", want.run_last, out_data.run_last);
            fail_count++;
          end
          if (out_data.expr_done !== want.expr_done) begin
            $error("expr_done expected %b got %b", want.expr_done, out_data.expr_done);
            fail_count++;
          end
          if (out_data.error_code !== want.error_code) begin
            $error("error_code expected %0d got %0d", want.error_code, out_data.error_code);
            fail_count++;
          end
        end
      end
    end
  end

  // Ends the run when neither side moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
